### rtl/pfi_pkg.sv
// Shared types, constants and helper functions for the polyphase FIR interpolator.
`timescale 1ns / 1ps

package pfi_pkg;

  localparam int MaxInterp  = 16;
  localparam int MaxTaps    = 32;

  localparam int PhaseW     = $clog2(MaxInterp);
  localparam int TapW       = $clog2(MaxTaps);
  localparam int CoefAddrW  = PhaseW + TapW;
  localparam int FactorW    = 5;
  localparam int TapsW      = 6;
  localparam int CfgDataW   = 6;
  localparam int CfgIndexW  = 1;
  localparam int SampleW    = 16;
  localparam int CoefInW    = 16;
  localparam int CoefW      = 21;
  localparam int OutW       = 24;
  localparam int ProdW      = CoefW + SampleW;
  localparam int AccW       = ProdW + TapW;
  localparam int RoundShift = 15;

  // Request codes
  localparam logic [1:0] ReqSample = 2'd0;
  localparam logic [1:0] ReqCoef   = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgFactor = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgTaps   = 1'b1;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [SampleW-1:0] sample_re;
    logic signed [SampleW-1:0] sample_im;
    logic [PhaseW-1:0]         coef_phase;
    logic [TapW-1:0]           coef_tap;
    logic signed [CoefInW-1:0] coef_value;
  } req_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_re;
    logic signed [OutW-1:0] out_im;
    logic [PhaseW-1:0]      out_phase;
    logic                   last;
  } rsp_t;

  // Tags that travel with each tap product through the MAC
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tap_ctl_t;

  function automatic logic [FactorW-1:0] eff_factor(input logic [FactorW-1:0] l);
    logic [FactorW-1:0] r;
    r = l;
    if (l == '0) r = FactorW'(1);
    else if (l > FactorW'(MaxInterp)) r = FactorW'(MaxInterp);
    return r;
  endfunction

  function automatic logic [TapsW-1:0] eff_taps(input logic [TapsW-1:0] t);
    logic [TapsW-1:0] r;
    r = t;
    if (t == '0) r = TapsW'(1);
    else if (t > TapsW'(MaxTaps)) r = TapsW'(MaxTaps);
    return r;
  endfunction

endpackage

### rtl/pfi_coef_ram.sv
// Coefficient store: one write port, one registered read port.
`timescale 1ns / 1ps

module pfi_coef_ram (
  input  logic                                clk,
  input  logic                                we,
  input  logic [pfi_pkg::CoefAddrW-1:0]       waddr,
  input  logic signed [pfi_pkg::CoefW-1:0]    wdata,
  input  logic [pfi_pkg::CoefAddrW-1:0]       raddr,
  output logic signed [pfi_pkg::CoefW-1:0]    rdata
);

  localparam int Depth = 1 << pfi_pkg::CoefAddrW;

  logic signed [pfi_pkg::CoefW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pfi_delay_ram.sv
// Sample delay line: memory with per-entry valid bits so reset and clear act at once.
`timescale 1ns / 1ps

module pfi_delay_ram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic                          we,
  input  logic [pfi_pkg::TapW-1:0]      waddr,
  input  logic [2*pfi_pkg::SampleW-1:0] wdata,
  input  logic [pfi_pkg::TapW-1:0]      raddr,
  output logic [2*pfi_pkg::SampleW-1:0] rdata
);

  logic [2*pfi_pkg::SampleW-1:0] mem [pfi_pkg::MaxTaps];
  logic [pfi_pkg::MaxTaps-1:0]   vld;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // an entry not written since the last clear reads as zero
    rdata <= vld[raddr] ? mem[raddr] : '0;
  end

endmodule

### rtl/pfi_mac.sv
// Shared complex multiply-accumulate with round-half-up and 24-bit saturation.
`timescale 1ns / 1ps

module pfi_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  pfi_pkg::tap_ctl_t                 ctl,
  input  logic signed [pfi_pkg::CoefW-1:0]  coef,
  input  logic signed [pfi_pkg::SampleW-1:0] x_re,
  input  logic signed [pfi_pkg::SampleW-1:0] x_im,
  output logic                              res_vld,
  output logic signed [pfi_pkg::OutW-1:0]   res_re,
  output logic signed [pfi_pkg::OutW-1:0]   res_im
);

  localparam int ShW = pfi_pkg::AccW - pfi_pkg::RoundShift;

  pfi_pkg::tap_ctl_t                ctl2;
  logic signed [pfi_pkg::ProdW-1:0] prod_re;
  logic signed [pfi_pkg::ProdW-1:0] prod_im;
  logic signed [pfi_pkg::AccW-1:0]  acc_re;
  logic signed [pfi_pkg::AccW-1:0]  acc_im;
  logic                             acc_done;
  logic signed [pfi_pkg::AccW-1:0]  rnd_re;
  logic signed [pfi_pkg::AccW-1:0]  rnd_im;
  logic signed [ShW-1:0]            sh_re;
  logic signed [ShW-1:0]            sh_im;
  logic signed [pfi_pkg::OutW-1:0]  sat_re;
  logic signed [pfi_pkg::OutW-1:0]  sat_im;

  function automatic logic signed [pfi_pkg::OutW-1:0] sat_out(input logic signed [ShW-1:0] v);
    logic signed [pfi_pkg::OutW-1:0] r;
    r = v[pfi_pkg::OutW-1:0];
    // out of range when the bits above the output sign disagree with it
    if (v[ShW-1:pfi_pkg::OutW-1] != {(ShW-pfi_pkg::OutW+1){v[ShW-1]}}) begin
      r = v[ShW-1] ? {1'b1, {(pfi_pkg::OutW-1){1'b0}}} : {1'b0, {(pfi_pkg::OutW-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    rnd_re = acc_re + pfi_pkg::AccW'(1 << (pfi_pkg::RoundShift - 1));
    rnd_im = acc_im + pfi_pkg::AccW'(1 << (pfi_pkg::RoundShift - 1));
    sh_re  = rnd_re[pfi_pkg::AccW-1:pfi_pkg::RoundShift];
    sh_im  = rnd_im[pfi_pkg::AccW-1:pfi_pkg::RoundShift];
    sat_re = sat_out(sh_re);
    sat_im = sat_out(sh_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2     <= '0;
      acc_done <= 1'b0;
      res_vld  <= 1'b0;
    end else begin
      ctl2     <= ctl;
      acc_done <= ctl2.vld && ctl2.last;
      res_vld  <= acc_done;
    end
  end

  always_ff @(posedge clk) begin
    prod_re <= coef * x_re;
    prod_im <= coef * x_im;
    if (ctl2.vld) begin
      acc_re <= ctl2.first ? pfi_pkg::AccW'(prod_re) : acc_re + pfi_pkg::AccW'(prod_re);
      acc_im <= ctl2.first ? pfi_pkg::AccW'(prod_im) : acc_im + pfi_pkg::AccW'(prod_im);
    end
    if (acc_done) begin
      res_re <= sat_re;
      res_im <= sat_im;
    end
  end

endmodule

### rtl/polyphase_fir_interpolator.sv
// Top level of the complex polyphase FIR interpolator: sequencer, stores and output register.
`timescale 1ns / 1ps

// Complex polyphase FIR interpolator. Three kinds of request item arrive on
// the req channel: a coefficient write stores coef_value times the current
// interpolation factor at (coef_phase, coef_tap); a clear empties the delay
// line; a sample is pushed into the 32-deep delay line and then yields one
// rsp item per phase, phase 0 first, with last set on the final one. One
// complex MAC is shared by every tap of every phase, fed by the one read port
// of each of the coefficient and delay memories, one tap a cycle. Each phase
// issues its taps, flushes them through the MAC pipeline and then pushes the
// result to the output register; a stalled rsp holds the push until the
// output register is free. req_stall is high for the whole run. Every
// coefficient entry that a run reads must have been written first (zeros as
// padding); unwritten entries read as garbage. Configuration must be written
// only while no sample run is in progress; the block itself does not enforce this.

module polyphase_fir_interpolator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  pfi_pkg::req_t                      req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output pfi_pkg::rsp_t                      rsp,
  input  logic                               cfg_we,
  input  logic [pfi_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [pfi_pkg::CfgDataW-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    Idle,
    Issue,
    Flush,
    Push
  } state_t;

  state_t                            state;
  logic [pfi_pkg::FactorW-1:0]       interpolation_factor;
  logic [pfi_pkg::TapsW-1:0]         taps_per_phase;
  logic [pfi_pkg::TapW-1:0]          wp;
  logic [pfi_pkg::PhaseW-1:0]        phase;
  logic [pfi_pkg::TapW-1:0]          tap;
  pfi_pkg::tap_ctl_t                 ctl_s1;

  logic [pfi_pkg::FactorW-1:0]       l_eff;
  logic [pfi_pkg::TapsW-1:0]         t_eff;
  logic                              req_acc;
  logic                              last_tap;
  logic                              last_phase;
  logic                              out_free;
  logic signed [pfi_pkg::CoefW:0]    gain_prod;
  logic                              coef_we;
  logic                              dly_we;
  logic                              dly_clr;
  logic [pfi_pkg::TapW-1:0]          wp_next;
  logic [pfi_pkg::TapW-1:0]          dly_raddr;
  logic [2*pfi_pkg::SampleW-1:0]     dly_rdata;
  logic signed [pfi_pkg::CoefW-1:0]  coef_rdata;
  logic                              mac_vld;
  logic signed [pfi_pkg::OutW-1:0]   mac_re;
  logic signed [pfi_pkg::OutW-1:0]   mac_im;

  assign l_eff      = pfi_pkg::eff_factor(interpolation_factor);
  assign t_eff      = pfi_pkg::eff_taps(taps_per_phase);
  assign req_stall  = (state != Idle);
  assign req_acc    = req_valid && !req_stall;
  assign last_tap   = ({1'b0, tap} == t_eff - pfi_pkg::TapsW'(1));
  assign last_phase = ({1'b0, phase} == l_eff - pfi_pkg::FactorW'(1));
  assign out_free   = !rsp_valid || !rsp_stall;

  // Gain of at most 16 on a Q1.15 value always fits in 21 bits, so keeping the low 21 bits loses nothing.
  assign gain_prod  = (pfi_pkg::CoefW+1)'(req.coef_value) *
                      $signed({{(pfi_pkg::CoefW+1-pfi_pkg::FactorW){1'b0}}, l_eff});

  assign coef_we    = req_acc && (req.req_type == pfi_pkg::ReqCoef);
  assign dly_we     = req_acc && (req.req_type == pfi_pkg::ReqSample);
  assign dly_clr    = req_acc && (req.req_type == pfi_pkg::ReqClear);
  assign wp_next    = wp + pfi_pkg::TapW'(1);
  // k-th newest sample sits k slots behind the write pointer
  assign dly_raddr  = wp - tap;

  pfi_coef_ram u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr ({req.coef_phase, req.coef_tap}),
    .wdata (gain_prod[pfi_pkg::CoefW-1:0]),
    .raddr ({phase, tap}),
    .rdata (coef_rdata)
  );

  pfi_delay_ram u_delay_ram (
    .clk   (clk),
    .rst   (rst),
    .clr   (dly_clr),
    .we    (dly_we),
    .waddr (wp_next),
    .wdata ({req.sample_re, req.sample_im}),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  pfi_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_s1),
    .coef    (coef_rdata),
    .x_re    (dly_rdata[2*pfi_pkg::SampleW-1:pfi_pkg::SampleW]),
    .x_im    (dly_rdata[pfi_pkg::SampleW-1:0]),
    .res_vld (mac_vld),
    .res_re  (mac_re),
    .res_im  (mac_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= Idle;
      interpolation_factor <= pfi_pkg::FactorW'(1);
      taps_per_phase       <= pfi_pkg::TapsW'(1);
      wp                   <= '0;
      phase                <= '0;
      tap                  <= '0;
      ctl_s1               <= '0;
      rsp_valid            <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pfi_pkg::CfgFactor: interpolation_factor <= cfg_data[pfi_pkg::FactorW-1:0];
          pfi_pkg::CfgTaps:   taps_per_phase       <= cfg_data[pfi_pkg::TapsW-1:0];
          default: ;
        endcase
      end

      // drop the output item once it is taken, unless Push refills it this cycle
      if (rsp_valid && !rsp_stall && (state != Push)) begin
        rsp_valid <= 1'b0;
      end

      // tag the tap whose memory reads land next cycle
      ctl_s1.vld   <= (state == Issue);
      ctl_s1.first <= (tap == '0);
      ctl_s1.last  <= last_tap;

      unique case (state)
        Idle: begin
          if (dly_clr) begin
            wp <= '0;
          end else if (dly_we) begin
            wp    <= wp_next;
            phase <= '0;
            tap   <= '0;
            state <= Issue;
          end
        end
        Issue: begin
          if (last_tap) begin
            state <= Flush;
          end else begin
            tap <= tap + pfi_pkg::TapW'(1);
          end
        end
        Flush: begin
          if (mac_vld) begin
            state <= Push;
          end
        end
        Push: begin
          // hold the MAC result until the output register is free
          if (out_free) begin
            rsp_valid     <= 1'b1;
            rsp.out_re    <= mac_re;
            rsp.out_im    <= mac_im;
            rsp.out_phase <= phase;
            rsp.last      <= last_phase;
            tap           <= '0;
            if (last_phase) begin
              state <= Idle;
            end else begin
              phase <= phase + pfi_pkg::PhaseW'(1);
              state <= Issue;
            end
          end
        end
        default: state <= Idle;
      endcase
    end
  end

endmodule
